@@ rtl/msbp_pkg.sv @@
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Shared types, constants and helper functions for the packer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msbp_pkg;

  localparam int WordBits  = 32;
  localparam int LenBits   = 20;
  localparam int CntBits   = 6;
  localparam int WordsBits = 18;

  localparam logic [LenBits-1:0]   ResetLength = 20'd4;
  localparam logic [WordsBits-1:0] WordsMax    = 18'h3FFFF;

  typedef enum logic [1:0] {
    OP_WRITE      = 2'd0,
    OP_ALIGN_ZERO = 2'd1,
    OP_ALIGN_ONE  = 2'd2,
    OP_FLUSH      = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 operation;
    logic [WordBits-1:0] code_value;
    logic [5:0]          code_length;
  } item_t;

  typedef struct packed {
    logic                word_valid;
    logic [WordBits-1:0] packed_word;
    logic                overflow_error;
    logic [WordBits-1:0] total_bits;
    logic [7:0]          partial_byte;
    logic [2:0]          partial_bit_count;
  } result_t;

  // Words of capacity for a packet length in bytes, rounded up and saturated; below 4 bytes gives none.
  function automatic logic [WordsBits-1:0] capacity_words(input logic [LenBits-1:0] len);
    logic [LenBits:0]   sum;
    logic [LenBits-2:0] words;
    begin
      sum   = {1'b0, len} + 21'd3;
      words = sum[LenBits:2];
      if (len < 20'd4) begin
        capacity_words = '0;
      end else if (words > {1'b0, WordsMax}) begin
        capacity_words = WordsMax;
      end else begin
        capacity_words = words[WordsBits-1:0];
      end
    end
  endfunction

  function automatic logic [WordBits-1:0] swap_bytes(input logic [WordBits-1:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/msbp_in_stage.sv @@
// ----------------------------------------------------------------------------
// Input stage
// Registers one input item; takes a new one while empty or whenever the held item moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_in_stage
  import msbp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       held_valid,
  output item_t      held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/msbp_pack_core.sv @@
// ----------------------------------------------------------------------------
// Packing core
// Holds the accumulator state and computes one item's update and result.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_pack_core
  import msbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [LenBits-1:0] cfg_length,
  input  wire logic               advance,
  input  wire item_t              item,
  output result_t                 result
);

  logic [WordBits-1:0]  accum_word, accum_word_next;
  logic [CntBits-1:0]   free_bits, free_bits_next;
  logic [WordsBits-1:0] words_left, words_left_next;
  logic [WordBits-1:0]  bit_count, bit_count_next;

  logic [CntBits-1:0]  n;
  logic [WordBits-1:0] v;
  logic [WordBits-1:0] vm;
  logic                flush;
  logic [CntBits-1:0]  free_sub;
  logic [CntBits-1:0]  shift;
  logic [WordBits-1:0] bit_sum;
  logic [WordBits-1:0] bit_round;
  logic [WordBits-1:0] moved;
  logic [2:0]          rem;

  always_comb begin
    n     = '0;
    v     = '0;
    flush = 1'b0;
    unique case (item.operation)
      OP_WRITE: begin
        n = (item.code_length > 6'd32) ? 6'd32 : item.code_length;
        v = item.code_value;
      end
      OP_ALIGN_ZERO: begin
        n = {3'b000, free_bits[2:0]};
      end
      OP_ALIGN_ONE: begin
        n = {3'b000, free_bits[2:0]};
        v = ~(32'hFFFF_FFFF << free_bits[2:0]);
      end
      OP_FLUSH: begin
        flush = 1'b1;
      end
    endcase

    // A clamped length of 32 keeps every bit; shorter codes drop stray bits.
    vm        = n[5] ? v : (v & ~(32'hFFFF_FFFF << n[4:0]));
    free_sub  = free_bits - n;
    shift     = n - free_bits;
    bit_sum   = bit_count + {26'd0, n};
    bit_round = bit_count + 32'd7;
    moved     = accum_word | (vm >> shift[4:0]);

    accum_word_next       = accum_word;
    free_bits_next        = free_bits;
    words_left_next       = words_left;
    bit_count_next        = bit_count;
    result.word_valid     = 1'b0;
    result.packed_word    = '0;
    result.overflow_error = 1'b0;

    if (flush) begin
      if (words_left == '0) begin
        result.overflow_error = 1'b1;
      end else begin
        result.word_valid  = 1'b1;
        result.packed_word = swap_bytes(accum_word);
        bit_count_next     = {bit_round[31:3], 3'b000};
      end
    end else begin
      bit_count_next = bit_sum;
      if (n < free_bits) begin
        free_bits_next  = free_sub;
        accum_word_next = accum_word | (vm << free_sub[4:0]);
      end else if (words_left == '0) begin
        result.overflow_error = 1'b1;
      end else begin
        words_left_next    = words_left - 18'd1;
        result.word_valid  = 1'b1;
        result.packed_word = swap_bytes(moved);
        free_bits_next     = 6'd32 - shift;
        accum_word_next    = (shift == '0) ? '0 : (vm << free_bits_next[4:0]);
      end
    end

    result.total_bits = bit_count_next;

    // Unfinished byte, taken from the state this item leaves behind.
    rem = free_bits_next[2:0];
    if (rem != 3'd0) begin
      unique case (free_bits_next[4:3])
        2'd0: result.partial_byte = accum_word_next[7:0] >> rem;
        2'd1: result.partial_byte = accum_word_next[15:8] >> rem;
        2'd2: result.partial_byte = accum_word_next[23:16] >> rem;
        2'd3: result.partial_byte = accum_word_next[31:24] >> rem;
      endcase
      result.partial_bit_count = 3'd0 - rem;
    end else begin
      result.partial_byte      = '0;
      result.partial_bit_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum_word <= '0;
      free_bits  <= 6'd32;
      words_left <= capacity_words(ResetLength);
      bit_count  <= '0;
    end else if (cfg_write) begin
      accum_word <= '0;
      free_bits  <= 6'd32;
      words_left <= capacity_words(cfg_length);
      bit_count  <= '0;
    end else if (advance) begin
      accum_word <= accum_word_next;
      free_bits  <= free_bits_next;
      words_left <= words_left_next;
      bit_count  <= bit_count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/msbp_out_stage.sv @@
// ----------------------------------------------------------------------------
// Result stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_out_stage
  import msbp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_result,
  output logic         can_load,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/msb_first_bit_packer.sv @@
// An input item waits in the input register; its result is offered from the result register.
// Throughput: one item per cycle while out_ready is high; the accumulator update is a single pass.
// The input and result registers let a new transfer in while a result waits.
// Reset (rst, synchronous) empties both stages and restarts the packet with
// a length of 4 bytes, i.e. one word of capacity.
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Packs 0..32 bit codes MSB first into byte-swapped 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_first_bit_packer
  import msbp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration: packet length in bytes. Each write restarts the packet.
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [LenBits-1:0]  packet_length_bytes,
  // Input items.
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          operation,
  input  wire logic [WordBits-1:0] code_value,
  input  wire logic [5:0]          code_length,
  // Results, one per item.
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     word_valid,
  output logic [WordBits-1:0]      packed_word,
  output logic                     overflow_error,
  output logic [WordBits-1:0]      total_bits,
  output logic [7:0]               partial_byte,
  output logic [2:0]               partial_bit_count
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    advance;
  result_t step_result;
  result_t out_result;

  // Configuration writes must be issued only while the packer is idle; the block
  // itself does not enforce this, and cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  assign in_item.operation   = op_t'(operation);
  assign in_item.code_value  = code_value;
  assign in_item.code_length = code_length;

  // The held item moves into the result register, and updates the packer
  // state, whenever the result register is free or being emptied by a
  // transfer in the same cycle.
  assign advance = held_valid && can_load;

  msbp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Accumulator, free bit count, remaining capacity and running bit count
  // live here, with the single-pass update for one item.
  msbp_pack_core u_pack_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_length (packet_length_bytes),
    .advance    (advance),
    .item       (held_item),
    .result     (step_result)
  );

  msbp_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_result (step_result),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign word_valid        = out_result.word_valid;
  assign packed_word       = out_result.packed_word;
  assign overflow_error    = out_result.overflow_error;
  assign total_bits        = out_result.total_bits;
  assign partial_byte      = out_result.partial_byte;
  assign partial_bit_count = out_result.partial_bit_count;

endmodule

`default_nettype wire

@@ rtl/msbp_checker.sv @@
// ----------------------------------------------------------------------------
// Packer port checker
// Watches the result port of the packer and checks its consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module msbp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        word_valid,
  input wire logic [31:0] packed_word,
  input wire logic        overflow_error,
  input wire logic [31:0] total_bits,
  input wire logic [7:0]  partial_byte,
  input wire logic [2:0]  partial_bit_count
);

  // No result is offered right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result keeps its bit count.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_bits))
    else $error("stalled result changed");

  // A word and an overflow never come from the same item.
  a_word_or_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(word_valid && overflow_error))
    else $error("word and overflow both flagged");

  // Without a word, the word field is zero.
  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_valid |-> packed_word == 32'd0)
    else $error("packed word set without word transfer");

  // A byte-aligned stream has no unfinished byte bits.
  a_aligned_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && partial_bit_count == 3'd0 |-> partial_byte == 8'd0)
    else $error("partial byte set while aligned");

endmodule

bind msb_first_bit_packer msbp_checker u_msbp_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .word_valid        (word_valid),
  .packed_word       (packed_word),
  .overflow_error    (overflow_error),
  .total_bits        (total_bits),
  .partial_byte      (partial_byte),
  .partial_bit_count (partial_bit_count)
);

`default_nettype wire
